// ===== rtl/mplj_pkg.sv =====
package mplj_pkg;

   // Latency of the pipelined divider, from operands to registered quotient.
   localparam int DIV_QBITS = 33;
   localparam int DIV_LAT   = DIV_QBITS + 3;

   localparam int ROT_W    = 18;
   localparam int ROT_FRAC = 16;
   localparam int ROW_W    = 3 * ROT_W;

   localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
   localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

   typedef logic signed [31:0] q_type;

   typedef enum logic [2:0] {
      REG_ROT_ROW0 = 3'd0,
      REG_ROT_ROW1 = 3'd1,
      REG_ROT_ROW2 = 3'd2,
      REG_SHIFT_X  = 3'd3,
      REG_SHIFT_Y  = 3'd4,
      REG_SHIFT_Z  = 3'd5
   } reg_index_type;

   // Values that ride alongside the dividers.
   typedef struct packed {
      q_type [2:0] nr;
      q_type [2:0] u;
      q_type [2:0] d;
      q_type       g;
      q_type       denom;
      q_type       f;
      logic        degen;
   } side_type;

   function automatic q_type sat32(input logic signed [63:0] v);
      if (v > S32_MAX) begin
         return q_type'(S32_MAX);
      end else if (v < S32_MIN) begin
         return q_type'(S32_MIN);
      end
      return q_type'(v);
   endfunction

endpackage

// ===== rtl/mplj_if.sv =====
interface mplj_req_if;
   import mplj_pkg::*;
   logic  valid;
   logic  ready;
   q_type origin_x, origin_y, origin_z;
   q_type dir_x, dir_y, dir_z;
   q_type plane_pt_x, plane_pt_y, plane_pt_z;
   q_type normal_x, normal_y, normal_z;

   modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   plane_pt_x, plane_pt_y, plane_pt_z, normal_x, normal_y, normal_z,
                   input ready);
   modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                 plane_pt_x, plane_pt_y, plane_pt_z, normal_x, normal_y, normal_z,
                 output ready);
endinterface

interface mplj_rsp_if;
   import mplj_pkg::*;
   logic  valid;
   logic  ready;
   q_type path_length;
   q_type grad_tx, grad_ty, grad_tz;
   q_type grad_rx, grad_ry, grad_rz;
   logic  degenerate;

   modport source (output valid, path_length, grad_tx, grad_ty, grad_tz,
                   grad_rx, grad_ry, grad_rz, degenerate, input ready);
   modport sink (input valid, path_length, grad_tx, grad_ty, grad_tz,
                 grad_rx, grad_ry, grad_rz, degenerate, output ready);
endinterface

// ===== rtl/mplj_div.sv =====
module mplj_div
   import mplj_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic signed [33:0] num,
   input  q_type              den,
   output logic               out_valid,
   output q_type              quo
);

   localparam int NW = 34;
   localparam int QB = DIV_QBITS;
   localparam int DW = NW + FRAC_BITS + 1;
   localparam int RW = 33;

   logic [NW-1:0] an;
   logic [31:0]   ad;
   logic [DW-1:0] dd;

   logic          v0_ff;
   logic          neg0_ff;
   logic [31:0]   ad0_ff;
   logic [DW-1:0] dd0_ff;

   logic          v_ff   [0:QB];
   logic [RW-1:0] rem_ff [0:QB];
   logic [QB-1:0] quo_ff [0:QB];
   logic [DW-1:0] dd_ff  [0:QB];
   logic [31:0]   ad_ff  [0:QB];
   logic          neg_ff [0:QB];
   logic          ovf_ff [0:QB];

   logic [QB-1:0] mag;
   logic          vo_ff;
   q_type         quo_ff_out;

   // Magnitudes, with the rounding half of the divisor folded into the dividend.
   assign an = num[NW-1] ? NW'(-num) : NW'(num);
   assign ad = den[31] ? 32'(-den) : 32'(den);
   assign dd = (DW'(an) << FRAC_BITS) + DW'(ad >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff    <= 1'b0;
         v_ff[0]  <= 1'b0;
      end else if (en) begin
         v0_ff    <= in_valid;
         v_ff[0]  <= v0_ff;
      end
      if (en) begin
         neg0_ff    <= num[NW-1] ^ den[31];
         ad0_ff     <= ad;
         dd0_ff     <= dd;
         ovf_ff[0]  <= (dd0_ff >> QB) >= DW'(ad0_ff);
         rem_ff[0]  <= RW'(dd0_ff >> QB);
         quo_ff[0]  <= '0;
         dd_ff[0]   <= dd0_ff;
         ad_ff[0]   <= ad0_ff;
         neg_ff[0]  <= neg0_ff;
      end
   end

   // One quotient bit per stage, restoring.
   for (genvar i = 0; i < QB; i++) begin : g_bit
      logic [RW:0] trial;
      logic        ge;

      assign trial = {rem_ff[i], dd_ff[i][QB-1-i]};
      assign ge    = trial >= (RW+1)'(ad_ff[i]);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (en) begin
            v_ff[i+1] <= v_ff[i];
         end
         if (en) begin
            rem_ff[i+1] <= ge ? RW'(trial - (RW+1)'(ad_ff[i])) : RW'(trial);
            quo_ff[i+1] <= {quo_ff[i][QB-2:0], ge};
            dd_ff[i+1]  <= dd_ff[i];
            ad_ff[i+1]  <= ad_ff[i];
            neg_ff[i+1] <= neg_ff[i];
            ovf_ff[i+1] <= ovf_ff[i];
         end
      end
   end

   assign mag = ovf_ff[QB] ? '1 : quo_ff[QB];

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (en) begin
         vo_ff <= v_ff[QB];
      end
      if (en) begin
         if (neg_ff[QB]) begin
            quo_ff_out <= (mag > QB'(33'h080000000)) ? q_type'(32'h80000000)
                                                    : q_type'(-mag);
         end else begin
            quo_ff_out <= (mag > QB'(33'h07fffffff)) ? q_type'(32'h7fffffff)
                                                    : q_type'(mag);
         end
      end
   end

   assign out_valid = vo_ff;
   assign quo       = quo_ff_out;

endmodule

// ===== rtl/mirror_path_length_jacobian.sv =====
// Mirror path length and pose gradient. Each transfer on req_ch carries one ray
// (origin a, unit direction u) and one mirror plane in the body frame (point p,
// normal n); the block answers on rsp_ch with the path length f*g, the
// translation gradient f*N and the rotation gradient N x (alph*g*u + f*(t-a)),
// where N = R*n, beta = u.N, g = p.n + (t-a).N, denom = 2*beta^2 - 1,
// f = beta/denom and alph = -(2*beta^2+1)/denom^2. The pose R, t lives in six
// registers on the csr_ port (64-bit data, register i at byte address 8*i); the
// user is to write it only while no ray is in flight, and the block does not
// enforce this. Values are signed fixed point with FRAC_BITS fraction bits,
// rotation elements signed Q2.16; every product is rounded half up and every
// intermediate and output saturates to 32 bits. A denominator of exactly zero
// gives all-zero outputs with degenerate set. The block takes one ray per clock
// while rsp_ch is not stalled, through six stages of dot products, two division
// passes of 36 stages each in series (beta/denom and the numerator of alph in
// the first, the second division of alph after it) and five gradient stages. A
// stalled rsp_ch holds the whole pipeline; no transfer is lost or repeated.
module mirror_path_length_jacobian
   import mplj_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   mplj_req_if.sink     req_ch,
   mplj_rsp_if.source   rsp_ch,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [5:0]   csr_paddr,
   input  logic [63:0]  csr_pwdata,
   output logic [63:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int PW = 64 - FRAC_BITS;
   localparam int RPW = 64 - ROT_FRAC;
   localparam logic signed [63:0] HALF_Q = 64'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [63:0] ONE_Q  = 64'sd1 <<< FRAC_BITS;
   localparam logic signed [63:0] HALF_R = 64'sd1 <<< (ROT_FRAC - 1);

   // Product of two Q values, rounded half up to FRAC_BITS fraction bits.
   function automatic logic signed [PW-1:0] qmul(input q_type a, input q_type b);
      logic signed [63:0] pr;
      pr = 64'(a) * 64'(b) + HALF_Q;
      return PW'(pr >>> FRAC_BITS);
   endfunction

   function automatic logic signed [RPW-1:0] rmul(input logic signed [ROT_W-1:0] r,
                                                 input q_type b);
      logic signed [63:0] pr;
      pr = 64'(r) * 64'(b) + HALF_R;
      return RPW'(pr >>> ROT_FRAC);
   endfunction

   // ------------------------------------------------------------------
   // Pose registers
   // ------------------------------------------------------------------
   logic [ROW_W-1:0] rot_row_ff [0:2];
   q_type            shift_ff   [0:2];
   reg_index_type    csr_idx;
   logic             csr_wr;

   assign csr_idx    = reg_index_type'(csr_paddr[5:3]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_row_ff[0] <= ROW_W'(65536);
         rot_row_ff[1] <= ROW_W'(65536) << ROT_W;
         rot_row_ff[2] <= ROW_W'(65536) << (2 * ROT_W);
         shift_ff[0]   <= '0;
         shift_ff[1]   <= '0;
         shift_ff[2]   <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_ROT_ROW0: rot_row_ff[0] <= csr_pwdata[ROW_W-1:0];
            REG_ROT_ROW1: rot_row_ff[1] <= csr_pwdata[ROW_W-1:0];
            REG_ROT_ROW2: rot_row_ff[2] <= csr_pwdata[ROW_W-1:0];
            REG_SHIFT_X:  shift_ff[0]   <= csr_pwdata[31:0];
            REG_SHIFT_Y:  shift_ff[1]   <= csr_pwdata[31:0];
            REG_SHIFT_Z:  shift_ff[2]   <= csr_pwdata[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_ROT_ROW0: csr_prdata = 64'(rot_row_ff[0]);
         REG_ROT_ROW1: csr_prdata = 64'(rot_row_ff[1]);
         REG_ROT_ROW2: csr_prdata = 64'(rot_row_ff[2]);
         REG_SHIFT_X:  csr_prdata = 64'(unsigned'(shift_ff[0]));
         REG_SHIFT_Y:  csr_prdata = 64'(unsigned'(shift_ff[1]));
         REG_SHIFT_Z:  csr_prdata = 64'(unsigned'(shift_ff[2]));
         default:      csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Flow control: the whole pipeline moves when the output register is free.
   // ------------------------------------------------------------------
   logic adv;
   logic rsp_valid_ff;

   assign adv          = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   q_type a_in [0:2];
   q_type u_in [0:2];
   q_type p_in [0:2];
   q_type n_in [0:2];

   assign a_in = '{req_ch.origin_x, req_ch.origin_y, req_ch.origin_z};
   assign u_in = '{req_ch.dir_x, req_ch.dir_y, req_ch.dir_z};
   assign p_in = '{req_ch.plane_pt_x, req_ch.plane_pt_y, req_ch.plane_pt_z};
   assign n_in = '{req_ch.normal_x, req_ch.normal_y, req_ch.normal_z};

   // Stage 1: rotation and plane products, t - a.
   logic                   s1_valid_ff;
   logic signed [RPW-1:0]  s1_rn_ff [0:2][0:2];
   logic signed [PW-1:0]   s1_pn_ff [0:2];
   q_type                  s1_d_ff  [0:2];
   q_type                  s1_u_ff  [0:2];

   // Stage 2: N and p.n.
   logic  s2_valid_ff;
   q_type s2_nr_ff [0:2];
   q_type s2_pn_ff;
   q_type s2_d_ff  [0:2];
   q_type s2_u_ff  [0:2];

   // Stage 3: u.N and (t-a).N products.
   logic                 s3_valid_ff;
   logic signed [PW-1:0] s3_un_ff [0:2];
   logic signed [PW-1:0] s3_dn_ff [0:2];
   q_type                s3_pn_ff;
   q_type                s3_nr_ff [0:2];
   q_type                s3_d_ff  [0:2];
   q_type                s3_u_ff  [0:2];

   // Stage 4: beta and g.
   logic  s4_valid_ff;
   q_type s4_beta_ff;
   q_type s4_g_ff;
   q_type s4_nr_ff [0:2];
   q_type s4_d_ff  [0:2];
   q_type s4_u_ff  [0:2];

   // Stage 5: beta squared.
   logic                 s5_valid_ff;
   logic signed [PW-1:0] s5_bsq_ff;
   q_type                s5_beta_ff;
   q_type                s5_g_ff;
   q_type                s5_nr_ff [0:2];
   q_type                s5_d_ff  [0:2];
   q_type                s5_u_ff  [0:2];

   // Stage 6: denominator and the numerator of q.
   logic               s6_valid_ff;
   q_type              s6_beta_ff;
   q_type              s6_denom_ff;
   logic signed [33:0] s6_numq_ff;
   side_type           s6_side_ff;

   q_type              bsq_c;
   logic signed [63:0] denom_c;

   assign bsq_c   = sat32(64'(s5_bsq_ff));
   assign denom_c = 64'(bsq_c) * 64'sd2 - ONE_Q;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_ch.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
      end
      if (adv) begin
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
               s1_rn_ff[r][k] <= rmul(rot_row_ff[r][ROT_W*k +: ROT_W], n_in[k]);
            end
            s1_pn_ff[r] <= qmul(p_in[r], n_in[r]);
            s1_d_ff[r]  <= sat32(64'(shift_ff[r]) - 64'(a_in[r]));
            s1_u_ff[r]  <= u_in[r];
         end

         for (int r = 0; r < 3; r++) begin
            s2_nr_ff[r] <= sat32(64'(s1_rn_ff[r][0]) + 64'(s1_rn_ff[r][1])
                                 + 64'(s1_rn_ff[r][2]));
         end
         s2_pn_ff <= sat32(64'(s1_pn_ff[0]) + 64'(s1_pn_ff[1]) + 64'(s1_pn_ff[2]));
         s2_d_ff  <= s1_d_ff;
         s2_u_ff  <= s1_u_ff;

         for (int k = 0; k < 3; k++) begin
            s3_un_ff[k] <= qmul(s2_u_ff[k], s2_nr_ff[k]);
            s3_dn_ff[k] <= qmul(s2_d_ff[k], s2_nr_ff[k]);
         end
         s3_pn_ff <= s2_pn_ff;
         s3_nr_ff <= s2_nr_ff;
         s3_d_ff  <= s2_d_ff;
         s3_u_ff  <= s2_u_ff;

         s4_beta_ff <= sat32(64'(s3_un_ff[0]) + 64'(s3_un_ff[1]) + 64'(s3_un_ff[2]));
         s4_g_ff    <= sat32(64'(s3_pn_ff) + 64'(sat32(64'(s3_dn_ff[0])
                                 + 64'(s3_dn_ff[1]) + 64'(s3_dn_ff[2]))));
         s4_nr_ff   <= s3_nr_ff;
         s4_d_ff    <= s3_d_ff;
         s4_u_ff    <= s3_u_ff;

         s5_bsq_ff  <= qmul(s4_beta_ff, s4_beta_ff);
         s5_beta_ff <= s4_beta_ff;
         s5_g_ff    <= s4_g_ff;
         s5_nr_ff   <= s4_nr_ff;
         s5_d_ff    <= s4_d_ff;
         s5_u_ff    <= s4_u_ff;

         s6_beta_ff  <= s5_beta_ff;
         s6_denom_ff <= sat32(denom_c);
         s6_numq_ff  <= 34'(64'(bsq_c) * 64'sd2 + ONE_Q);
         for (int k = 0; k < 3; k++) begin
            s6_side_ff.nr[k] <= s5_nr_ff[k];
            s6_side_ff.u[k]  <= s5_u_ff[k];
            s6_side_ff.d[k]  <= s5_d_ff[k];
         end
         s6_side_ff.g     <= s5_g_ff;
         s6_side_ff.denom <= sat32(denom_c);
         s6_side_ff.f     <= '0;
         s6_side_ff.degen <= (sat32(denom_c) == '0);
      end
   end

   // ------------------------------------------------------------------
   // First division pass: f = beta/denom and q = (2*beta^2+1)/denom.
   // ------------------------------------------------------------------
   logic     f_valid;
   logic     q_valid;
   q_type    f_quo;
   q_type    q_quo;
   side_type side1_ff [0:DIV_LAT-1];
   side_type side2_in;

   mplj_div #(.FRAC_BITS(FRAC_BITS)) u_div_f (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s6_valid_ff),
      .num       (34'(s6_beta_ff)),
      .den       (s6_denom_ff),
      .out_valid (f_valid),
      .quo       (f_quo)
   );

   mplj_div #(.FRAC_BITS(FRAC_BITS)) u_div_q (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s6_valid_ff),
      .num       (s6_numq_ff),
      .den       (s6_denom_ff),
      .out_valid (q_valid),
      .quo       (q_quo)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         side1_ff[0] <= s6_side_ff;
         for (int k = 1; k < DIV_LAT; k++) begin
            side1_ff[k] <= side1_ff[k-1];
         end
      end
   end

   always_comb begin
      side2_in   = side1_ff[DIV_LAT-1];
      side2_in.f = f_quo;
   end

   // ------------------------------------------------------------------
   // Second division pass: q/denom, the magnitude of alph.
   // ------------------------------------------------------------------
   logic     a_valid;
   q_type    a_quo;
   side_type side2_ff [0:DIV_LAT-1];
   side_type sd;

   mplj_div #(.FRAC_BITS(FRAC_BITS)) u_div_a (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (f_valid && q_valid),
      .num       (34'(q_quo)),
      .den       (side2_in.denom),
      .out_valid (a_valid),
      .quo       (a_quo)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         side2_ff[0] <= side2_in;
         for (int k = 1; k < DIV_LAT; k++) begin
            side2_ff[k] <= side2_ff[k-1];
         end
      end
   end

   assign sd = side2_ff[DIV_LAT-1];

   // ------------------------------------------------------------------
   // Gradient assembly.
   // ------------------------------------------------------------------
   logic                 h_valid_ff;
   logic signed [PW-1:0] h_ag_ff;
   side_type             h_side_ff;

   logic                 i_valid_ff;
   logic signed [PW-1:0] i_pa_ff [0:2];
   logic signed [PW-1:0] i_pf_ff [0:2];
   side_type             i_side_ff;

   logic                 j_valid_ff;
   q_type                j_w_ff [0:2];
   side_type             j_side_ff;

   logic                 k_valid_ff;
   logic signed [PW-1:0] k_fg_ff;
   logic signed [PW-1:0] k_fn_ff [0:2];
   logic signed [PW-1:0] k_c_ff  [0:5];
   logic                 k_degen_ff;

   q_type path_ff, gtx_ff, gty_ff, gtz_ff, grx_ff, gry_ff, grz_ff;
   logic  degen_ff;
   q_type alph_c;
   q_type ag_c;

   assign alph_c = sat32(-64'(a_quo));
   assign ag_c   = sat32(64'(h_ag_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff   <= 1'b0;
         i_valid_ff   <= 1'b0;
         j_valid_ff   <= 1'b0;
         k_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         h_valid_ff   <= a_valid;
         i_valid_ff   <= h_valid_ff;
         j_valid_ff   <= i_valid_ff;
         k_valid_ff   <= j_valid_ff;
         rsp_valid_ff <= k_valid_ff;
      end
      if (adv) begin
         h_ag_ff   <= qmul(alph_c, sd.g);
         h_side_ff <= sd;

         for (int k = 0; k < 3; k++) begin
            i_pa_ff[k] <= qmul(ag_c, h_side_ff.u[k]);
            i_pf_ff[k] <= qmul(h_side_ff.f, h_side_ff.d[k]);
         end
         i_side_ff <= h_side_ff;

         for (int k = 0; k < 3; k++) begin
            j_w_ff[k] <= sat32(64'(i_pa_ff[k]) + 64'(i_pf_ff[k]));
         end
         j_side_ff <= i_side_ff;

         k_fg_ff <= qmul(j_side_ff.f, j_side_ff.g);
         for (int k = 0; k < 3; k++) begin
            k_fn_ff[k] <= qmul(j_side_ff.f, j_side_ff.nr[k]);
         end
         k_c_ff[0]  <= qmul(j_side_ff.nr[1], j_w_ff[2]);
         k_c_ff[1]  <= qmul(j_side_ff.nr[2], j_w_ff[1]);
         k_c_ff[2]  <= qmul(j_side_ff.nr[2], j_w_ff[0]);
         k_c_ff[3]  <= qmul(j_side_ff.nr[0], j_w_ff[2]);
         k_c_ff[4]  <= qmul(j_side_ff.nr[0], j_w_ff[1]);
         k_c_ff[5]  <= qmul(j_side_ff.nr[1], j_w_ff[0]);
         k_degen_ff <= j_side_ff.degen;

         // A zero denominator forces every field to zero.
         if (k_degen_ff) begin
            path_ff <= '0;
            gtx_ff  <= '0;
            gty_ff  <= '0;
            gtz_ff  <= '0;
            grx_ff  <= '0;
            gry_ff  <= '0;
            grz_ff  <= '0;
         end else begin
            path_ff <= sat32(64'(k_fg_ff));
            gtx_ff  <= sat32(64'(k_fn_ff[0]));
            gty_ff  <= sat32(64'(k_fn_ff[1]));
            gtz_ff  <= sat32(64'(k_fn_ff[2]));
            grx_ff  <= sat32(64'(k_c_ff[0]) - 64'(k_c_ff[1]));
            gry_ff  <= sat32(64'(k_c_ff[2]) - 64'(k_c_ff[3]));
            grz_ff  <= sat32(64'(k_c_ff[4]) - 64'(k_c_ff[5]));
         end
         degen_ff <= k_degen_ff;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.path_length = path_ff;
   assign rsp_ch.grad_tx     = gtx_ff;
   assign rsp_ch.grad_ty     = gty_ff;
   assign rsp_ch.grad_tz     = gtz_ff;
   assign rsp_ch.grad_rx     = grx_ff;
   assign rsp_ch.grad_ry     = gry_ff;
   assign rsp_ch.grad_rz     = grz_ff;
   assign rsp_ch.degenerate  = degen_ff;

endmodule
